/* hw/rtl/xsfb_pkg.sv */
// xsfb_pkg: shared types and constants for the XOR sprite frame store.
// No dependencies; imported by xsfb_ctrl, xsfb_dp and the top level.
`timescale 1ns / 1ps

package xsfb_pkg;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;
	localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
	localparam int FRAME_SIZE    = ROW_BYTES * SCREEN_HEIGHT;

	localparam int COL_W  = $clog2(SCREEN_WIDTH);
	localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int BSEL_W = $clog2(ROW_BYTES);
	localparam int ADDR_W = $clog2(FRAME_SIZE);

	localparam logic [7:0] PIXEL_MSB = 8'b1000_0000;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_SET   = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_DRAW  = 2'd3
	} cmd_e;

	typedef struct packed {
		logic [1:0]       command;
		logic [COL_W-1:0] pos_x;
		logic [ROW_W-1:0] pos_y;
		logic [3:0]       row_index;
		logic [7:0]       sprite_row;
		logic             last_row;
	} in_item_t;

	typedef struct packed {
		logic pixel_on;
		logic collision;
		logic sprite_done;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // latch the accepted item
		logic clear;   // drop every byte back to zero
		logic mod0;    // first byte: old data valid, write if needed
		logic mod1;    // second byte of a sprite row
		logic rd1;     // read address selects the second byte
		logic finish;  // load the output register
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] command;  // command of the latched item
	} dp_sts_t;

endpackage

/* hw/rtl/xsfb_dp.sv */
// xsfb_dp: frame memory with per-byte valid bits, item latch, read-modify-write
// logic, collision flag and output register. Depends on xsfb_pkg.
`timescale 1ns / 1ps

module xsfb_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  xsfb_pkg::in_item_t in_data,
	input  xsfb_pkg::dp_ctl_t  ctl,
	output xsfb_pkg::dp_sts_t  sts,
	output xsfb_pkg::out_item_t out_data
);
	import xsfb_pkg::*;

	in_item_t            item_q;
	out_item_t           out_q;
	logic [7:0]          mem [FRAME_SIZE];
	logic [FRAME_SIZE-1:0] valid_q;
	logic [7:0]          rdata_q;
	logic                vbit_q;
	logic                coll_q;
	logic                pix_q;

	logic [ROW_W-1:0]    row;
	logic [BSEL_W-1:0]   bsel0, bsel1;
	logic [ADDR_W-1:0]   addr0, addr1, raddr;
	logic [15:0]         spr_wide;
	logic [7:0]          mask0, mask1, mask_cur, pix_mask, old, wdata;
	logic                is_draw, is_set, is_test, wr_en;

	assign is_draw = (item_q.command == CMD_DRAW);
	assign is_set  = (item_q.command == CMD_SET);
	assign is_test = (item_q.command == CMD_TEST);

	// row wraps modulo the screen height (power of two)
	assign row   = is_draw ? ROW_W'(item_q.pos_y + ROW_W'(item_q.row_index)) : item_q.pos_y;
	assign bsel0 = item_q.pos_x[COL_W-1:3];
	assign bsel1 = BSEL_W'(bsel0 + BSEL_W'(1));
	assign addr0 = {row, bsel0};
	assign addr1 = {row, bsel1};
	assign raddr = ctl.rd1 ? addr1 : addr0;

	assign spr_wide = {item_q.sprite_row, 8'h00} >> item_q.pos_x[2:0];
	assign mask0    = spr_wide[15:8];
	assign mask1    = spr_wide[7:0];
	assign pix_mask = PIXEL_MSB >> item_q.pos_x[2:0];
	assign mask_cur = is_draw ? (ctl.mod1 ? mask1 : mask0) : pix_mask;

	assign old   = vbit_q ? rdata_q : 8'h00;
	assign wdata = is_draw ? (old ^ mask_cur) : (old | mask_cur);
	assign wr_en = (ctl.mod0 && (is_set || is_draw)) || ctl.mod1;

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (wr_en) begin
			mem[ctl.mod1 ? addr1 : addr0] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vbit_q  <= 1'b0;
		end else begin
			vbit_q <= valid_q[raddr];
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[ctl.mod1 ? addr1 : addr0] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q <= 1'b0;
		end else if (ctl.load) begin
			if (in_data.command == CMD_DRAW && in_data.row_index == 4'd0) begin
				coll_q <= 1'b0;
			end
		end else if ((ctl.mod0 || ctl.mod1) && is_draw && |(old & mask_cur)) begin
			coll_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= in_data;
		end
		if (ctl.mod0) begin
			pix_q <= |(old & pix_mask);
		end
		if (ctl.finish) begin
			out_q.pixel_on    <= is_test & pix_q;
			out_q.collision   <= is_draw & coll_q;
			out_q.sprite_done <= is_draw & item_q.last_row;
		end
	end

	assign sts.command = item_q.command;
	assign out_data    = out_q;

endmodule

/* hw/rtl/xsfb_ctrl.sv */
// xsfb_ctrl: sequencer for one command at a time and output valid tracking.
// Depends on xsfb_pkg.
`timescale 1ns / 1ps

module xsfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_command,
	output logic              out_valid,
	input  logic              out_ready,
	input  xsfb_pkg::dp_sts_t sts,
	output xsfb_pkg::dp_ctl_t ctl
);
	import xsfb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_MOD0 = 5'b00100,
		ST_MOD1 = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					if (in_command == CMD_CLEAR) begin
						ctl.clear = 1'b1;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_MOD0;
			end
			ST_MOD0: begin
				ctl.mod0 = 1'b1;
				if (sts.command == CMD_DRAW) begin
					ctl.rd1 = 1'b1;
					state_d = ST_MOD1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MOD1: begin
				ctl.mod1 = 1'b1;
				ctl.rd1  = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/xor_sprite_framebuffer_core.sv */
// xor_sprite_framebuffer_core: top level of the 64x32 monochrome XOR sprite store.
// Instantiates xsfb_ctrl and xsfb_dp; types from xsfb_pkg.
//
//  channel | handshake          | payload             | direction
//  --------+--------------------+---------------------+----------
//  in      | in_valid/in_ready  | in_data (in_item_t) | into core
//  out     | out_valid/out_ready| out_data(out_item_t)| out of core
//
// Set pixel and draw are read-modify-writes of the frame memory, which
// has one read and one write port (one read then one write per byte, two
// bytes per row). Clear needs no sweep: per-byte valid bits drop together.
// Reset (arst_n) clears the frame, the collision flag and the output valid.
// The result sits in an output register, so the next item is taken and run
// while it waits; that item's result then holds the sequencer in its final
// state, with in_ready low, until the out side takes the waiting transfer.
`timescale 1ns / 1ps

module xor_sprite_framebuffer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  xsfb_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output xsfb_pkg::out_item_t out_data
);
	import xsfb_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	// sequencer: one command in flight, steps the memory port
	xsfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_command (in_data.command),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (sts),
		.ctl        (ctl)
	);

	// frame memory, masks, collision flag and result register
	xsfb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.ctl      (ctl),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
